### rtl/lae_pkg.sv
// Shared types and constants for the line assembler with echo.
// No dependencies; imported by every module of the block.
package lae_pkg;

    localparam int unsigned MAX_LINE = 256;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned NRES     = 3;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [POS_W-1:0] LIM_RESET = POS_W'(80);
    localparam logic [POS_W-1:0] LIM_MAX   = POS_W'(MAX_LINE);

    localparam logic [0:0] REG_MAX_LINE_LENGTH = 1'b0;

    typedef struct packed {
        logic             echo_valid;
        logic [7:0]       echo_byte;
        logic             store_valid;
        logic [POS_W-1:0] store_index;
        logic [7:0]       store_byte;
        logic             line_done;
        logic [POS_W-1:0] line_length;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             line_open;
    } line_state_t;

    typedef struct packed {
        result_t [NRES-1:0] res;
        logic [1:0]         count;
    } bundle_t;

endpackage

### rtl/lae_decode.sv
// Per-byte decode: builds the one to three results and the next line state.
// Depends on lae_pkg.
module lae_decode (
    input  logic [7:0]              rx_byte,
    input  logic [lae_pkg::POS_W-1:0] max_line_length,
    input  lae_pkg::line_state_t    state_cur,
    output lae_pkg::line_state_t    state_next,
    output lae_pkg::bundle_t        bundle
);
    import lae_pkg::*;

    logic [POS_W-1:0] lim;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_dec;
    logic [POS_W-1:0] pos_adv;
    logic             end_bs;
    logic             end_adv;

    always_comb begin
        if (max_line_length == '0) begin
            lim = POS_W'(1);
        end else if (max_line_length > LIM_MAX) begin
            lim = LIM_MAX;
        end else begin
            lim = max_line_length;
        end
        pos     = state_cur.line_open ? state_cur.pos : '0;
        pos_dec = pos - POS_W'(1);
        pos_adv = (rx_byte != CH_LF && rx_byte != CH_BS) ? pos + POS_W'(1) : pos;
        end_bs  = pos_dec >= lim;
        end_adv = pos_adv >= lim;
    end

    always_comb begin
        bundle     = '0;
        state_next = state_cur;
        bundle.res[0].echo_valid  = 1'b1;
        bundle.res[0].echo_byte   = rx_byte;
        bundle.res[0].store_valid = 1'b1;
        bundle.res[0].store_index = pos;
        bundle.res[0].store_byte  = rx_byte;
        if (rx_byte == CH_BS && pos != '0) begin
            bundle.count              = 2'd3;
            bundle.res[1].echo_valid  = 1'b1;
            bundle.res[1].echo_byte   = CH_SP;
            bundle.res[2].echo_valid  = 1'b1;
            bundle.res[2].echo_byte   = CH_BS;
            bundle.res[2].last        = 1'b1;
            if (end_bs) begin
                bundle.res[2].store_valid = 1'b1;
                bundle.res[2].store_index = pos_dec;
                bundle.res[2].store_byte  = CH_NUL;
                bundle.res[2].line_done   = 1'b1;
                bundle.res[2].line_length = pos_dec;
                state_next = '0;
            end else begin
                state_next.pos       = pos_dec;
                state_next.line_open = 1'b1;
            end
        end else if (rx_byte == CH_CR) begin
            bundle.count              = 2'd2;
            bundle.res[1].echo_valid  = 1'b1;
            bundle.res[1].echo_byte   = CH_LF;
            bundle.res[1].store_valid = 1'b1;
            bundle.res[1].store_index = pos;
            bundle.res[1].store_byte  = CH_NUL;
            bundle.res[1].line_done   = 1'b1;
            bundle.res[1].line_length = pos;
            bundle.res[1].last        = 1'b1;
            state_next = '0;
        end else if (end_adv) begin
            bundle.count              = 2'd2;
            bundle.res[1].store_valid = 1'b1;
            bundle.res[1].store_index = pos_adv;
            bundle.res[1].store_byte  = CH_NUL;
            bundle.res[1].line_done   = 1'b1;
            bundle.res[1].line_length = pos_adv;
            bundle.res[1].last        = 1'b1;
            state_next = '0;
        end else begin
            bundle.count         = 2'd1;
            bundle.res[0].last   = 1'b1;
            state_next.pos       = pos_adv;
            state_next.line_open = 1'b1;
        end
    end

endmodule

### rtl/lae_out_seq.sv
// Result register: holds one byte's results and hands them out one per transfer.
// Depends on lae_pkg.
module lae_out_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  lae_pkg::bundle_t    bundle_in,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output lae_pkg::result_t    m_res
);
    import lae_pkg::*;

    bundle_t    bundle_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_fire;

    assign m_valid  = cnt_reg != 2'd0;
    assign out_fire = m_valid && m_ready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign m_res    = bundle_reg.res[idx_reg];

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = bundle_in.count;
            idx_next = 2'd0;
        end else if (out_fire) begin
            cnt_next = cnt_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle_in;
        end
    end

endmodule

### rtl/line_assembler_with_echo.sv
// Line assembler with echo: top level with register port and line state.
// Depends on lae_pkg, lae_decode and lae_out_seq.
// The first result of a byte is registered and offered in the cycle after its transfer.
// Throughput: one result per cycle while m_ready holds, one to three results per byte; the
// result register is reloaded in the cycle its last result is taken.
// Reset (aresetn low, synchronous): no results pending, position 0, no line
// open, max_line_length back to 80.
module line_assembler_with_echo (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_echo_valid,
    output logic [7:0]  m_echo_byte,
    output logic        m_store_valid,
    output logic [8:0]  m_store_index,
    output logic [7:0]  m_store_byte,
    output logic        m_line_done,
    output logic [8:0]  m_line_length,
    output logic        m_last
);
    import lae_pkg::*;

    logic [POS_W-1:0] max_len_reg;
    line_state_t      state_reg;
    line_state_t      state_next;
    bundle_t          bundle;
    result_t          res;
    logic             can_load;
    logic             in_fire;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_MAX_LINE_LENGTH);
    assign prdata  = (paddr[2] == REG_MAX_LINE_LENGTH) ? {23'd0, max_len_reg} : 32'd0;

    assign s_ready = can_load;
    assign in_fire = s_valid && can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LIM_RESET;
            state_reg   <= '0;
        end else begin
            if (cfg_wr) begin
                max_len_reg <= pwdata[POS_W-1:0];
            end
            if (in_fire) begin
                state_reg <= state_next;
            end
        end
    end

    lae_decode u_decode (
        .rx_byte         (s_rx_byte),
        .max_line_length (max_len_reg),
        .state_cur       (state_reg),
        .state_next      (state_next),
        .bundle          (bundle)
    );

    lae_out_seq u_out_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_fire),
        .bundle_in (bundle),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (res)
    );

    assign m_echo_valid  = res.echo_valid;
    assign m_echo_byte   = res.echo_byte;
    assign m_store_valid = res.store_valid;
    assign m_store_index = res.store_index;
    assign m_store_byte  = res.store_byte;
    assign m_line_done   = res.line_done;
    assign m_line_length = res.line_length;
    assign m_last        = res.last;

endmodule

### sim/tb_line_assembler_with_echo.sv
// Testbench for line_assembler_with_echo: directed and random byte streams under
// random sender gaps and receiver stalls, checked beat by beat against a line model.
// Depends on rtl/lae_pkg.sv and rtl/line_assembler_with_echo.sv.
`timescale 1ns / 100ps

import lae_pkg::*;

class line_echo_model;
    logic [8:0] limit_reg;
    logic [8:0] wpos;
    bit         line_open;
    result_t    echo_store_q[$];
    int         errors;

    function new();
        limit_reg = LIM_RESET;
        wpos      = '0;
        line_open = 1'b0;
        errors    = 0;
    endfunction

    function void set_limit(logic [8:0] v);
        limit_reg = v;
    endfunction

    function int pending();
        return echo_store_q.size();
    endfunction

    function result_t beat(bit ev, logic [7:0] eb, bit sv, logic [8:0] si, logic [7:0] sbyte,
                           bit ld, logic [8:0] ll, bit lst);
        result_t r;
        r.echo_valid  = ev;
        r.echo_byte   = eb;
        r.store_valid = sv;
        r.store_index = si;
        r.store_byte  = sbyte;
        r.line_done   = ld;
        r.line_length = ll;
        r.last        = lst;
        return r;
    endfunction

    // one received byte -> the echo/store beats it produces
    function void take_rx_byte(logic [7:0] ch);
        int unsigned lim;
        logic [8:0]  pos;
        bit          done;
        lim = 32'(limit_reg);
        if (lim == 0) lim = 1;
        if (lim > MAX_LINE) lim = MAX_LINE;
        if (!line_open) begin
            wpos      = '0;
            line_open = 1'b1;
        end
        pos = wpos;
        if (ch == CH_BS && pos != 0) begin
            echo_store_q.push_back(beat(1'b1, ch, 1'b1, pos, ch, 1'b0, '0, 1'b0));
            echo_store_q.push_back(beat(1'b1, CH_SP, 1'b0, '0, '0, 1'b0, '0, 1'b0));
            pos  = pos - 9'd1;
            done = (pos >= lim);
            if (done) begin
                echo_store_q.push_back(beat(1'b1, CH_BS, 1'b1, pos, CH_NUL, 1'b1, pos, 1'b1));
            end else begin
                echo_store_q.push_back(beat(1'b1, CH_BS, 1'b0, '0, '0, 1'b0, '0, 1'b1));
            end
            wpos      = done ? '0 : pos;
            line_open = !done;
        end else if (ch == CH_CR) begin
            echo_store_q.push_back(beat(1'b1, ch, 1'b1, pos, ch, 1'b0, '0, 1'b0));
            echo_store_q.push_back(beat(1'b1, CH_LF, 1'b1, pos, CH_NUL, 1'b1, pos, 1'b1));
            wpos      = '0;
            line_open = 1'b0;
        end else begin
            if (ch != CH_LF && ch != CH_BS) pos = pos + 9'd1;
            done = (pos >= lim);
            echo_store_q.push_back(beat(1'b1, ch, 1'b1, wpos, ch, 1'b0, '0, !done));
            if (done) begin
                echo_store_q.push_back(beat(1'b0, '0, 1'b1, pos, CH_NUL, 1'b1, pos, 1'b1));
                wpos      = '0;
                line_open = 1'b0;
            end else begin
                wpos = pos;
            end
        end
    endfunction

    function void cmp(string fname, logic [8:0] exp, logic [8:0] got);
        if (got !== exp) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, fname, exp, got);
        end
    endfunction

    function void check_beat(result_t got);
        result_t exp;
        if (echo_store_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
            return;
        end
        exp = echo_store_q.pop_front();
        cmp("echo_valid", 9'(exp.echo_valid), 9'(got.echo_valid));
        cmp("echo_byte", 9'(exp.echo_byte), 9'(got.echo_byte));
        cmp("store_valid", 9'(exp.store_valid), 9'(got.store_valid));
        cmp("store_index", exp.store_index, got.store_index);
        cmp("store_byte", 9'(exp.store_byte), 9'(got.store_byte));
        cmp("line_done", 9'(exp.line_done), 9'(got.line_done));
        cmp("line_length", exp.line_length, got.line_length);
        cmp("last", 9'(exp.last), 9'(got.last));
    endfunction
endclass

module tb_line_assembler_with_echo;

    localparam logic [2:0] LIMIT_ADDR = 3'(4 * REG_MAX_LINE_LENGTH);

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_echo_valid;
    logic [7:0]  m_echo_byte;
    logic        m_store_valid;
    logic [8:0]  m_store_index;
    logic [7:0]  m_store_byte;
    logic        m_line_done;
    logic [8:0]  m_line_length;
    logic        m_last;

    line_echo_model lines = new();

    int burst_left = 0;
    int stall_mode = 0;
    int stall_cnt = 0;

    line_assembler_with_echo DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_echo_valid  (m_echo_valid),
        .m_echo_byte   (m_echo_byte),
        .m_store_valid (m_store_valid),
        .m_store_index (m_store_index),
        .m_store_byte  (m_store_byte),
        .m_line_done   (m_line_done),
        .m_line_length (m_line_length),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stall pattern, re-chosen at random
    always @(negedge aclk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt  = $urandom_range(20, 80);
        end else begin
            stall_cnt--;
        end
        case (stall_mode)
            0: m_ready = 1'b1;
            1: m_ready = 1'($urandom_range(0, 1));
            2: m_ready = ($urandom_range(0, 3) == 0);
            default: m_ready = ~m_ready;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            lines.check_beat('{m_echo_valid, m_echo_byte, m_store_valid, m_store_index,
                               m_store_byte, m_line_done, m_line_length, m_last});
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_byte(input logic [7:0] ch);
        s_rx_byte = ch;
        s_valid   = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        lines.take_rx_byte(ch);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (lines.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // write max_line_length, then read it back
    task automatic set_line_limit(input logic [8:0] v);
        drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = LIMIT_ADDR;
        pwdata  = 32'(v);
        @(negedge aclk);
        penable = 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        lines.set_limit(v);
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        if (prdata !== 32'(v)) begin
            lines.errors++;
            $display("%0t: max_line_length readback mismatch, expected %h, actual %h",
                     $realtime, 32'(v), prdata);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [7:0] pick_byte(int cr_pct, int bs_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < cr_pct) return CH_CR;
        if (r < cr_pct + bs_pct) return CH_BS;
        if (r < cr_pct + bs_pct + 4) return CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_phase(input logic [8:0] lim, input int n, input int cr_pct,
                             input int bs_pct);
        set_line_limit(lim);
        repeat (n) send_byte(pick_byte(cr_pct, bs_pct));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset limit of 80: backspace and LF at zero, byte extremes, erase, CR
        send_byte(CH_BS);
        send_byte(CH_LF);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(CH_BS);
        send_byte(CH_CR);
        send_byte(CH_CR);
        // one-character lines; zero acts as one
        set_line_limit(9'd1);
        send_byte(8'h78);
        send_byte(CH_BS);
        send_byte(CH_LF);
        set_line_limit(9'd0);
        send_byte(8'h79);
        // limit lowered under an open line: next LF, then next backspace, ends it
        set_line_limit(9'd3);
        send_byte(8'h61);
        send_byte(8'h62);
        set_line_limit(9'd1);
        send_byte(CH_LF);
        set_line_limit(9'd3);
        send_byte(8'h61);
        send_byte(8'h62);
        set_line_limit(9'd1);
        send_byte(CH_BS);

        run_phase(9'd7, 15, 8, 12);
        run_phase(9'd1, 10, 10, 10);
        run_phase(9'd0, 10, 10, 10);
        run_phase(9'd20, 15, 5, 15);
        drain();
        repeat (15) send_byte(pick_byte(5, 15));
        run_phase(9'd256, 15, 10, 10);
        // long lines up to the 256 cap
        run_phase(9'h1FF, 270, 0, 3);
        run_phase(9'd3, 15, 10, 20);
        run_phase(9'd80, 15, 10, 10);
        run_phase(9'($urandom_range(2, 40)), 15, 5, 10);

        s_valid = 1'b0;
        while (lines.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (lines.errors == 0 && lines.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
